/* sv/ewr_pkg.sv */
// ----------------------------------------------------------------------------
// ewr_pkg
// Types and constants shared by the even-walk reachability block.
// ----------------------------------------------------------------------------
`default_nettype none

package ewr_pkg;

   localparam int unsigned VID_W  = 5;
   localparam int unsigned MASK_W = 32;
   // graph rows beyond this count can never be addressed by a 5-bit vertex
   localparam int unsigned ROW_CAP = 32;

   typedef enum logic [1:0] {
      OP_CONNECT    = 2'd0,
      OP_DISCONNECT = 2'd1,
      OP_TEST       = 2'd2,
      OP_REACH      = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [VID_W-1:0]  vertex_a;
      logic [VID_W-1:0]  vertex_b;
   } req_type;

   typedef struct packed {
      logic              edge_present;
      logic [MASK_W-1:0] reach_mask;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/ewr_adj_ram.sv */
// ----------------------------------------------------------------------------
// ewr_adj_ram
// Adjacency row store: one write port, one registered read port, and a
// valid bit per row so that rows never written read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ewr_adj_ram #(
   parameter int unsigned ROWS = 32,
   parameter int unsigned AW   = 5
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire logic [ROWS-1:0] wr_data,
   input  wire logic [AW-1:0]   rd_addr,
   output logic      [ROWS-1:0] rd_data
);

   logic [ROWS-1:0] mem [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic [ROWS-1:0] rdata_ff;
   logic            rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rvalid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

/* sv/ewr_pick_low.sv */
// ----------------------------------------------------------------------------
// ewr_pick_low
// Picks the lowest set vertex of a pending set and returns the set without it.
// ----------------------------------------------------------------------------
`default_nettype none

module ewr_pick_low #(
   parameter int unsigned ROWS = 32,
   parameter int unsigned AW   = 5
) (
   input  wire logic [ROWS-1:0] pending,
   output logic      [AW-1:0]   index,
   output logic      [ROWS-1:0] remaining
);

   logic [ROWS-1:0] low_bit;

   assign low_bit   = pending & (~pending + {{(ROWS-1){1'b0}}, 1'b1});
   assign remaining = pending & ~low_bit;

   // one-hot to binary
   always_comb begin
      index = '0;
      for (int k = 0; k < ROWS; k++) begin
         if (low_bit[k]) begin
            index = index | AW'(k);
         end
      end
   end

endmodule

`default_nettype wire

/* sv/even_walk_reachability.sv */
// ----------------------------------------------------------------------------
// even_walk_reachability
// Undirected graph store with edge updates, edge tests and even-walk reach.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on the clock edge where start is high and busy low;
//   req_data carries the op and two vertex indices. Exactly one response
//   follows: rsp_valid is high for one cycle with rsp_data alongside. The
//   receiver cannot stall, so the response is simply presented once.
// Steps:
//   connect / disconnect: write, read, write, respond; a vertex out of range
//   is answered straight from idle with no graph access. test: read, respond.
//   reach: each round expands the frontier by two hops; every hop reads one
//   adjacency row per set vertex through the single read port, one per cycle,
//   then waits for the last row to land and the hop to close. The shared
//   row read port sets the pace of a reach.
// Throughput:
//   one request at a time; busy drops in the response cycle, so the next
//   request can be taken while the response is presented.
// Reset:
//   synchronous, active high; the graph returns to no edges at once, busy
//   drops and no response is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module even_walk_reachability #(
   parameter int unsigned VERTICES = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire ewr_pkg::req_type req_data,
   output logic                 rsp_valid,
   output ewr_pkg::rsp_type     rsp_data
);

   localparam int unsigned ROWS = (VERTICES < ewr_pkg::ROW_CAP) ? VERTICES : ewr_pkg::ROW_CAP;
   localparam int unsigned AW   = $clog2(ROWS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_A,
      ST_RD_B,
      ST_WR_B,
      ST_TEST,
      ST_SCAN
   } state_type;

   state_type        state_ff, state_in;
   ewr_pkg::op_type  op_ff, op_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [AW-1:0]    b_ff, b_in;
   logic [ROWS-1:0]  reached_ff, reached_in;
   logic [ROWS-1:0]  pending_ff, pending_in;
   logic [ROWS-1:0]  acc_ff, acc_in;
   logic             hop_ff, hop_in;
   logic             outstanding_ff, outstanding_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ewr_pkg::rsp_type rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [ROWS-1:0]  wr_data;
   logic [AW-1:0]    rd_addr;
   logic [ROWS-1:0]  rd_data;
   logic [AW-1:0]    pick_index;
   logic [ROWS-1:0]  pick_rest;

   logic             a_ok, b_ok;
   logic [AW-1:0]    req_a, req_b;
   logic [ROWS-1:0]  acc_now;
   logic [ROWS-1:0]  fresh;

   ewr_adj_ram #(.ROWS(ROWS), .AW(AW)) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ewr_pick_low #(.ROWS(ROWS), .AW(AW)) u_pick (
      .pending   (pending_ff),
      .index     (pick_index),
      .remaining (pick_rest)
   );

   assign a_ok  = ({1'b0, req_data.vertex_a} < 6'(ROWS));
   assign b_ok  = ({1'b0, req_data.vertex_b} < 6'(ROWS));
   assign req_a = req_data.vertex_a[AW-1:0];
   assign req_b = req_data.vertex_b[AW-1:0];

   // a row read issued last cycle lands in the accumulator this cycle
   assign acc_now = outstanding_ff ? (acc_ff | rd_data) : acc_ff;
   assign fresh   = acc_ff & ~reached_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      reached_in     = reached_ff;
      pending_in     = pending_ff;
      acc_in         = acc_ff;
      hop_in         = hop_ff;
      outstanding_in = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = a_ff;
      wr_data        = rd_data;
      rd_addr        = a_ff;

      case (state_ff)
         ST_IDLE: begin
            rd_addr = req_a;
            if (start) begin
               op_in  = req_data.op;
               a_in   = req_a;
               b_in   = req_b;
               rsp_in = '0;
               case (req_data.op)
                  ewr_pkg::OP_CONNECT, ewr_pkg::OP_DISCONNECT: begin
                     if (a_ok && b_ok) begin
                        state_in = ST_WR_A;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ewr_pkg::OP_TEST: begin
                     if (a_ok && b_ok) begin
                        state_in = ST_TEST;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     if (a_ok) begin
                        reached_in = ROWS'(1) << req_a;
                        pending_in = ROWS'(1) << req_a;
                        acc_in     = '0;
                        hop_in     = 1'b0;
                        state_in   = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
               endcase
            end
         end

         ST_WR_A: begin
            wr_en   = 1'b1;
            wr_addr = a_ff;
            if (op_ff == ewr_pkg::OP_CONNECT) begin
               wr_data = rd_data | (ROWS'(1) << b_ff);
            end else begin
               wr_data = rd_data & ~(ROWS'(1) << b_ff);
            end
            state_in = ST_RD_B;
         end

         // separate read cycle so a self loop sees the row just written
         ST_RD_B: begin
            rd_addr  = b_ff;
            state_in = ST_WR_B;
         end

         ST_WR_B: begin
            wr_en   = 1'b1;
            wr_addr = b_ff;
            if (op_ff == ewr_pkg::OP_CONNECT) begin
               wr_data = rd_data | (ROWS'(1) << a_ff);
            end else begin
               wr_data = rd_data & ~(ROWS'(1) << a_ff);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_TEST: begin
            rsp_in.edge_present = rd_data[b_ff];
            rsp_valid_in        = 1'b1;
            state_in            = ST_IDLE;
         end

         ST_SCAN: begin
            rd_addr = pick_index;
            acc_in  = acc_now;
            if (pending_ff != '0) begin
               pending_in     = pick_rest;
               outstanding_in = 1'b1;
            end else if (!outstanding_ff) begin
               // hop closed: acc_ff holds the full neighbour set
               acc_in = '0;
               if (!hop_ff) begin
                  pending_in = acc_ff;
                  hop_in     = 1'b1;
               end else begin
                  reached_in = reached_ff | fresh;
                  pending_in = fresh;
                  hop_in     = 1'b0;
                  if (fresh == '0) begin
                     rsp_in.reach_mask = 32'(reached_ff);
                     rsp_valid_in      = 1'b1;
                     state_in          = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         outstanding_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         outstanding_ff <= outstanding_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff      <= op_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      reached_ff <= reached_in;
      pending_ff <= pending_in;
      acc_ff     <= acc_in;
      hop_ff     <= hop_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* bench/ewr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ewr_checker
// Tracks the graph held by the even-walk reachability block and checks every
// response against its own edge store and two-hop frontier expansion.
// ----------------------------------------------------------------------------
module ewr_checker #(
   parameter int unsigned VERTICES = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire ewr_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire ewr_pkg::rsp_type rsp_data,
   output int                    mismatches,
   output int                    outstanding
);

   typedef logic [ewr_pkg::ROW_CAP-1:0] row_type;

   row_type            graph_rows [ewr_pkg::ROW_CAP];
   ewr_pkg::rsp_type   pending_answers [$];
   int                 fault_tally;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      fault_tally = 0;
   end

   function automatic row_type live_vertices();
      row_type m;
      m = '0;
      for (int k = 0; k < ewr_pkg::ROW_CAP; k++)
         if (k < VERTICES) m[k] = 1'b1;
      return m;
   endfunction

   function automatic row_type neighbour_set(input row_type set);
      row_type acc;
      acc = '0;
      for (int k = 0; k < ewr_pkg::ROW_CAP; k++)
         if (set[k]) acc |= graph_rows[k];
      return acc & live_vertices();
   endfunction

   function automatic logic [ewr_pkg::MASK_W-1:0] even_walk_set(
         input logic [ewr_pkg::VID_W-1:0] origin);
      row_type reached;
      row_type frontier;
      row_type fresh;
      reached       = '0;
      reached[origin] = 1'b1;
      frontier      = reached;
      while (frontier != '0) begin
         fresh    = neighbour_set(neighbour_set(frontier)) & ~reached;
         reached |= fresh;
         frontier = fresh;
      end
      return reached[ewr_pkg::MASK_W-1:0];
   endfunction

   // applies the request to the graph copy and returns the answer it earns
   function automatic ewr_pkg::rsp_type answer_request(input ewr_pkg::req_type r);
      ewr_pkg::rsp_type ans;
      bit               both_live;
      ans       = '0;
      both_live = (r.vertex_a < VERTICES) && (r.vertex_b < VERTICES);
      case (r.op)
         ewr_pkg::OP_CONNECT: begin
            if (both_live) begin
               graph_rows[r.vertex_a][r.vertex_b] = 1'b1;
               graph_rows[r.vertex_b][r.vertex_a] = 1'b1;
            end
         end
         ewr_pkg::OP_DISCONNECT: begin
            if (both_live) begin
               graph_rows[r.vertex_a][r.vertex_b] = 1'b0;
               graph_rows[r.vertex_b][r.vertex_a] = 1'b0;
            end
         end
         ewr_pkg::OP_TEST: begin
            if (both_live) ans.edge_present = graph_rows[r.vertex_a][r.vertex_b];
         end
         default: begin
            if (r.vertex_a < VERTICES) ans.reach_mask = even_walk_set(r.vertex_a);
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      ewr_pkg::rsp_type want;
      if (reset) begin
         foreach (graph_rows[k]) graph_rows[k] = '0;
         pending_answers.delete();
      end else begin
         if (start && !busy) pending_answers.push_back(answer_request(req_data));
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response edge_present=%0b reach_mask=%h",
                        $time, rsp_data.edge_present, rsp_data.reach_mask);
               fault_tally++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.edge_present !== want.edge_present) begin
                  $display("%0t: edge_present expected %0b actual %0b",
                           $time, want.edge_present, rsp_data.edge_present);
                  fault_tally++;
               end
               if (rsp_data.reach_mask !== want.reach_mask) begin
                  $display("%0t: reach_mask expected %h actual %h",
                           $time, want.reach_mask, rsp_data.reach_mask);
                  fault_tally++;
               end
            end
         end
      end
      mismatches  <= fault_tally;
      outstanding <= pending_answers.size();
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives edge updates, edge tests and even-walk reach queries into the
// reachability block with random gaps; the checker beside it judges answers.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned VERTICES    = 32;
   localparam int          TARGET_REQS = 400;

   typedef logic [ewr_pkg::VID_W-1:0] vid_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             rsp_valid;
   ewr_pkg::req_type req_data;
   ewr_pkg::rsp_type rsp_data;
   int               mismatches;
   int               outstanding;
   int               sent;
   bit               steady;

   even_walk_reachability #(.VERTICES(VERTICES)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   ewr_checker #(.VERTICES(VERTICES)) u_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // holds start until the request is taken, then, unless steady, idles for a random gap
   task automatic issue(input ewr_pkg::op_type op, input vid_type a, input vid_type b);
      ewr_pkg::req_type r;
      int               gap;
      r.op       = op;
      r.vertex_a = a;
      r.vertex_b = b;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sent++;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every response still due
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // mostly a small cluster so edges meet and tests hit
   function automatic vid_type pick_vertex();
      if ($urandom_range(0, 2) == 0) return vid_type'($urandom_range(0, 31));
      return vid_type'($urandom_range(0, 9));
   endfunction

   // build a path or cycle, query it, then usually tear it down again
   task automatic chain_burst();
      vid_type nodes [8];
      int      len;
      bit      closed;
      len    = $urandom_range(2, 8);
      closed = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) nodes[k] = pick_vertex();
      for (int k = 0; k + 1 < len; k++)
         issue(ewr_pkg::OP_CONNECT, nodes[k], nodes[k+1]);
      if (closed) issue(ewr_pkg::OP_CONNECT, nodes[len-1], nodes[0]);
      issue(ewr_pkg::OP_REACH, nodes[$urandom_range(0, len-1)],
            vid_type'($urandom_range(0, 31)));
      issue(ewr_pkg::OP_TEST, nodes[$urandom_range(0, len-1)],
            nodes[$urandom_range(0, len-1)]);
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k + 1 < len; k++)
            issue(ewr_pkg::OP_DISCONNECT, nodes[k + 1], nodes[k]);
         if (closed) issue(ewr_pkg::OP_DISCONNECT, nodes[0], nodes[len-1]);
         issue(ewr_pkg::OP_REACH, nodes[0], vid_type'($urandom_range(0, 31)));
      end
   endtask

   task automatic single_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      issue(ewr_pkg::OP_CONNECT, pick_vertex(), pick_vertex());
      else if (pick < 55) issue(ewr_pkg::OP_DISCONNECT, pick_vertex(), pick_vertex());
      else if (pick < 75) issue(ewr_pkg::OP_TEST, pick_vertex(), pick_vertex());
      else issue(ewr_pkg::OP_REACH, pick_vertex(), vid_type'($urandom_range(0, 31)));
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      sent     = 0;
      steady   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty graph, extremes, mirror edge, self loop, odd cycles and removal
      issue(ewr_pkg::OP_REACH, 5'd0, 5'd0);
      issue(ewr_pkg::OP_TEST, 5'd0, 5'd31);
      issue(ewr_pkg::OP_CONNECT, 5'd0, 5'd31);
      issue(ewr_pkg::OP_TEST, 5'd31, 5'd0);
      issue(ewr_pkg::OP_REACH, 5'd0, 5'd31);
      issue(ewr_pkg::OP_CONNECT, 5'd31, 5'd1);
      issue(ewr_pkg::OP_REACH, 5'd0, 5'd0);
      issue(ewr_pkg::OP_CONNECT, 5'd5, 5'd5);
      issue(ewr_pkg::OP_TEST, 5'd5, 5'd5);
      issue(ewr_pkg::OP_CONNECT, 5'd1, 5'd5);
      issue(ewr_pkg::OP_REACH, 5'd0, 5'd31);
      issue(ewr_pkg::OP_REACH, 5'd31, 5'd0);
      issue(ewr_pkg::OP_DISCONNECT, 5'd5, 5'd5);
      issue(ewr_pkg::OP_REACH, 5'd0, 5'd10);
      issue(ewr_pkg::OP_DISCONNECT, 5'd31, 5'd0);
      issue(ewr_pkg::OP_TEST, 5'd0, 5'd31);
      issue(ewr_pkg::OP_REACH, 5'd31, 5'd21);
      issue(ewr_pkg::OP_CONNECT, 5'd31, 5'd31);
      issue(ewr_pkg::OP_REACH, 5'd31, 5'd31);
      issue(ewr_pkg::OP_DISCONNECT, 5'd10, 5'd20);
      issue(ewr_pkg::OP_CONNECT, 5'd21, 5'd10);
      issue(ewr_pkg::OP_TEST, 5'd10, 5'd21);
      issue(ewr_pkg::OP_REACH, 5'd21, 5'd31);
      drain();

      while (sent < TARGET_REQS) begin
         if ($urandom_range(0, 39) == 0) steady = ~steady;
         if ($urandom_range(0, 3) == 0) chain_burst();
         else single_random();
         if ($urandom_range(0, 29) == 0) drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
